// ===== src/sparse_feature_accumulator_defines.svh =====
// Assertion macros for the sparse feature accumulator.
`ifndef SPARSE_FEATURE_ACCUMULATOR_DEFINES_SVH
`define SPARSE_FEATURE_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFA_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sfa assertion failed");
`define SFA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sfa assertion failed");
`else
`define SFA_ASSERT_IMPL(label, pre, post)
`define SFA_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ===== src/sfa_pkg.sv =====
// Shared constants, types and functions of the sparse feature accumulator.
package sfa_pkg;

  localparam int ELEMENTS  = 256;
  localparam int FEATURES  = 1024;
  localparam int LANES     = 16;
  localparam int ACT_SHIFT = 6;
  localparam int ACT_MAX   = 127;

  localparam int WORD_W  = 16;
  localparam int CLIP_W  = 15;
  localparam int ACT_W   = 7;
  localparam int FEAT_W  = 10;
  localparam int ELEM_W  = 8;
  localparam int CMD_W   = 3;

  localparam int ROWS     = ELEMENTS / LANES;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int W_DEPTH  = FEATURES * ROWS;
  localparam int W_ADDR_W = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int A_DEPTH  = 2 * ROWS;
  localparam int A_ADDR_W = $clog2(A_DEPTH);
  localparam int SHIFT_W  = CLIP_W - ACT_SHIFT;

  localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(255);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LANES-1:0][WORD_W-1:0] row_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_MOVE   = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef struct packed {
    logic sub;
    logic acc_valid;
  } alu_ctrl_t;

  function automatic logic [ACT_W-1:0] activation(input word_t raw,
                                                  input logic [CLIP_W-1:0] clip);
    logic [CLIP_W-1:0]  v;
    logic [SHIFT_W-1:0] s;
    if (raw[WORD_W-1]) begin
      v = '0;
    end else if (raw[CLIP_W-1:0] > clip) begin
      v = clip;
    end else begin
      v = raw[CLIP_W-1:0];
    end
    s = SHIFT_W'(v >> ACT_SHIFT);
    if (s > SHIFT_W'(ACT_MAX)) begin
      return ACT_W'(ACT_MAX);
    end
    return s[ACT_W-1:0];
  endfunction

endpackage

// ===== src/sfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sfa_lane_alu.sv =====
// Lane-parallel add/subtract unit shared by every accumulator row update.
module sfa_lane_alu (
  input  sfa_pkg::row_t      acc,
  input  sfa_pkg::row_t      weight,
  input  sfa_pkg::alu_ctrl_t ctrl,
  output sfa_pkg::row_t      sum
);
  import sfa_pkg::*;

  always_comb begin
    word_t a;
    for (int l = 0; l < LANES; l++) begin
      a = ctrl.acc_valid ? acc[l] : '0;
      sum[l] = ctrl.sub ? word_t'(a - weight[l]) : word_t'(a + weight[l]);
    end
  end

endmodule

// ===== src/sparse_feature_accumulator.sv =====
// Sparse feature accumulator: weight table plus two accumulator vectors.
// Requests arrive on the s_axis channel: tuser carries the command and side,
// tdata the feature rows, element index and weight word. Every request gives
// exactly one result on m_axis (raw element and clipped activation, zeros
// for commands other than read). clip_max is written through cfg_we/cfg_wdata;
// the user must do so only while no request is in flight; the block does not
// enforce it. Weight writes pass through ST_WRITE, reads through ST_READ and
// ST_SELECT, add and remove through ST_UPDATE, move through two passes of
// ST_UPDATE; clear and unused commands go to ST_DONE. The update time is set
// by the accumulator RAM port: one row of LANES words is read and written
// back per cycle through the shared lane adder. One request is in flight at
// a time; s_axis_tready is high only between requests.
// Reset empties all accumulator rows at once through per-row valid bits and
// restores clip_max to 255; the weight table holds no reset value.
// A result waits in the output register while m_axis_tready is low; the next
// request is still taken and completes up to its result, then holds.
`include "sparse_feature_accumulator_defines.svh"

module sparse_feature_accumulator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sfa_pkg::CLIP_W-1:0] cfg_wdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // feature_a, feature_b, element, weight_value, zero pad
  input  logic [47:0]                s_axis_tdata,
  // command, side
  input  logic [3:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // raw_value, clipped_value, zero pad
  output logic [23:0]                m_axis_tdata
);
  import sfa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_UPDATE,
    ST_READ,
    ST_SELECT,
    ST_DONE
  } state_t;

  state_t              state;
  cmd_t                cmd;
  logic                side;
  logic [FEAT_W-1:0]   fa;
  logic [FEAT_W-1:0]   fb;
  logic [ELEM_W-1:0]   el;
  word_t               wv;
  logic [CLIP_W-1:0]   clip;

  logic                rd_active;
  logic [ROW_W-1:0]    rd_row;
  logic                pass;
  logic                sub;
  logic                wb_valid;
  logic [ROW_W-1:0]    wb_row;
  logic                wb_sub;
  logic                wb_acc_valid;
  logic [A_DEPTH-1:0]  acc_valid;

  word_t               res_raw;
  logic [ACT_W-1:0]    res_act;
  logic                m_valid;
  logic [23:0]         m_data;

  logic                accept;
  logic                issue;
  cmd_t                in_cmd;
  logic [FEAT_W-1:0]   in_fa;
  logic [FEAT_W-1:0]   in_fb;
  logic [ELEM_W-1:0]   in_el;
  logic [LANE_W-1:0]   lane_sel;
  logic [ROW_W-1:0]    el_row;
  logic [A_ADDR_W-1:0] acc_raddr;
  logic [A_ADDR_W-1:0] acc_waddr;
  logic [W_ADDR_W-1:0] w_raddr;
  logic [W_ADDR_W-1:0] w_waddr;
  logic [LANES-1:0]    w_we;
  row_t                acc_rdata;
  row_t                w_rdata;
  row_t                alu_sum;
  alu_ctrl_t           alu_ctrl;
  word_t               sel_raw;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  assign in_cmd = cmd_t'(s_axis_tuser[2:0]);
  assign in_fa  = s_axis_tdata[9:0];
  assign in_fb  = s_axis_tdata[19:10];
  assign in_el  = s_axis_tdata[27:20];

  assign lane_sel = LANE_W'(el % LANES);
  assign el_row   = ROW_W'(el / LANES);
  assign issue    = rd_active && !(wb_valid && wb_row == rd_row);

  always_comb begin
    if (state == ST_UPDATE) begin
      acc_raddr = A_ADDR_W'(A_ADDR_W'(ROWS) * A_ADDR_W'(side) + A_ADDR_W'(rd_row));
    end else begin
      acc_raddr = A_ADDR_W'(A_ADDR_W'(ROWS) * A_ADDR_W'(side) + A_ADDR_W'(el_row));
    end
  end

  assign acc_waddr = A_ADDR_W'(A_ADDR_W'(ROWS) * A_ADDR_W'(side) + A_ADDR_W'(wb_row));
  assign w_raddr   = W_ADDR_W'(W_ADDR_W'(ROWS) * W_ADDR_W'(pass ? fb : fa)
                               + W_ADDR_W'(rd_row));
  assign w_waddr   = W_ADDR_W'(W_ADDR_W'(ROWS) * W_ADDR_W'(fa) + W_ADDR_W'(el_row));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      w_we[l] = (state == ST_WRITE) && (lane_sel == LANE_W'(l));
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_weight
    sfa_ram #(
      .WIDTH(WORD_W),
      .DEPTH(W_DEPTH)
    ) u_weight_ram (
      .clk  (clk),
      .we   (w_we[g]),
      .waddr(w_waddr),
      .wdata(wv),
      .raddr(w_raddr),
      .rdata(w_rdata[g])
    );
  end

  sfa_ram #(
    .WIDTH(LANES * WORD_W),
    .DEPTH(A_DEPTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (wb_valid),
    .waddr(acc_waddr),
    .wdata(alu_sum),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  assign alu_ctrl.sub       = wb_sub;
  assign alu_ctrl.acc_valid = wb_acc_valid;

  sfa_lane_alu u_alu (
    .acc   (acc_rdata),
    .weight(w_rdata),
    .ctrl  (alu_ctrl),
    .sum   (alu_sum)
  );

  assign sel_raw = wb_acc_valid ? acc_rdata[lane_sel] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      clip         <= CLIP_RESET;
      acc_valid    <= '0;
      rd_active    <= 1'b0;
      wb_valid     <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        clip <= cfg_wdata;
      end
      if (m_valid && m_axis_tready && state != ST_DONE) begin
        m_valid <= 1'b0;
      end
      if (wb_valid) begin
        acc_valid[acc_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd       <= in_cmd;
            side      <= s_axis_tuser[3];
            fa        <= in_fa;
            fb        <= in_fb;
            el        <= in_el;
            wv        <= s_axis_tdata[43:28];
            res_raw   <= '0;
            res_act   <= '0;
            rd_row    <= '0;
            pass      <= 1'b0;
            sub       <= (in_cmd == CMD_REMOVE) || (in_cmd == CMD_MOVE);
            case (in_cmd) inside
              CMD_WRITE: begin
                if (32'(in_fa) < FEATURES && 32'(in_el) < ELEMENTS) begin
                  state <= ST_WRITE;
                end else begin
                  state <= ST_DONE;
                end
              end
              CMD_CLEAR: begin
                acc_valid <= '0;
                state     <= ST_DONE;
              end
              CMD_ADD, CMD_REMOVE: begin
                if (32'(in_fa) < FEATURES) begin
                  rd_active <= 1'b1;
                  state     <= ST_UPDATE;
                end else begin
                  state <= ST_DONE;
                end
              end
              CMD_MOVE: begin
                if (32'(in_fa) < FEATURES && 32'(in_fb) < FEATURES) begin
                  rd_active <= 1'b1;
                  state     <= ST_UPDATE;
                end else begin
                  state <= ST_DONE;
                end
              end
              CMD_READ: begin
                if (32'(in_el) < ELEMENTS) begin
                  state <= ST_READ;
                end else begin
                  state <= ST_DONE;
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_UPDATE: begin
          wb_valid <= issue;
          if (issue) begin
            wb_row       <= rd_row;
            wb_sub       <= sub;
            wb_acc_valid <= acc_valid[acc_raddr];
            if (rd_row == ROW_W'(ROWS - 1)) begin
              rd_row <= '0;
              if (cmd == CMD_MOVE && !pass) begin
                pass <= 1'b1;
                sub  <= 1'b0;
              end else begin
                rd_active <= 1'b0;
              end
            end else begin
              rd_row <= rd_row + 1'b1;
            end
          end
          if (!rd_active && !wb_valid) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          wb_acc_valid <= acc_valid[acc_raddr];
          state        <= ST_SELECT;
        end
        ST_SELECT: begin
          res_raw <= sel_raw;
          res_act <= activation(sel_raw, clip);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_valid || m_axis_tready) begin
            m_valid <= 1'b1;
            m_data  <= {1'b0, res_act, res_raw};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SFA_ASSERT_NEXT(a_accept_busy, accept, !s_axis_tready)
  `SFA_ASSERT_IMPL(a_wb_in_update, wb_valid, state == ST_UPDATE)
  `SFA_ASSERT_NEXT(a_drain, state == ST_UPDATE && !rd_active, !wb_valid)
  `SFA_ASSERT_IMPL(a_update_row, rd_active, state == ST_UPDATE || state == ST_IDLE)

endmodule

// ===== tb/sparse_feature_accumulator_tb.sv =====
// Self-checking testbench for the sparse feature accumulator with a behavioral predictor.
`timescale 1ns / 100ps

module sparse_feature_accumulator_tb;
  import sfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int WEIGHTS_FULL     = 0;
  localparam int WEIGHTS_SMALL    = 1;
  localparam int WEIGHTS_POSITIVE = 2;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_REQUESTS = 15;
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned LONG_HOLD_AT   = 200;
  localparam int unsigned LONG_HOLD      = 300;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic              side;
    logic [FEAT_W-1:0] feature_a;
    logic [FEAT_W-1:0] feature_b;
    logic [ELEM_W-1:0] element;
    logic [WORD_W-1:0] weight_value;
  } request_t;

  typedef struct {
    logic [WORD_W-1:0] raw_value;
    logic [ACT_W-1:0]  clipped_value;
  } readout_t;

  class accumulator_scoreboard;
    bit [WORD_W-1:0] weights [FEATURES*ELEMENTS];
    bit [WORD_W-1:0] acc [2][ELEMENTS];
    bit [CLIP_W-1:0] clip_max;
    readout_t        readout_q [$];
    int unsigned     mismatches;

    function new();
      clip_max   = CLIP_RESET;
      mismatches = 0;
      foreach (acc[s, e]) acc[s][e] = '0;
    endfunction

    function void set_clip(bit [CLIP_W-1:0] value);
      clip_max = value;
    endfunction

    function int unsigned pending();
      return readout_q.size();
    endfunction

    function bit [ACT_W-1:0] activation_of(bit [WORD_W-1:0] raw);
      int level;
      if (raw[WORD_W-1]) begin
        level = 0;
      end else if (int'(raw) > int'(clip_max)) begin
        level = int'(clip_max);
      end else begin
        level = int'(raw);
      end
      level = level >> ACT_SHIFT;
      if (level > ACT_MAX) begin
        level = ACT_MAX;
      end
      return ACT_W'(level);
    endfunction

    function void apply_row(bit s, bit [FEAT_W-1:0] row, bit subtract);
      int base;
      base = int'(row) * ELEMENTS;
      for (int e = 0; e < ELEMENTS; e++) begin
        if (subtract) acc[s][e] = acc[s][e] - weights[base + e];
        else acc[s][e] = acc[s][e] + weights[base + e];
      end
    endfunction

    function void note_request(request_t rq);
      readout_t res;
      res.raw_value     = '0;
      res.clipped_value = '0;
      case (rq.command)
        CMD_WRITE: begin
          weights[int'(rq.feature_a) * ELEMENTS + int'(rq.element)] = rq.weight_value;
        end
        CMD_CLEAR: begin
          foreach (acc[s, e]) acc[s][e] = '0;
        end
        CMD_ADD: apply_row(rq.side, rq.feature_a, 1'b0);
        CMD_REMOVE: apply_row(rq.side, rq.feature_a, 1'b1);
        CMD_MOVE: begin
          apply_row(rq.side, rq.feature_a, 1'b1);
          apply_row(rq.side, rq.feature_b, 1'b0);
        end
        CMD_READ: begin
          res.raw_value     = acc[rq.side][rq.element];
          res.clipped_value = activation_of(res.raw_value);
        end
        default: ;
      endcase
      readout_q.push_back(res);
    endfunction

    function void check_result(logic [WORD_W-1:0] raw, logic [ACT_W-1:0] clipped);
      readout_t want;
      if (readout_q.size() == 0) begin
        $error("result with nothing pending: raw_value %0d clipped_value %0d",
               $signed(raw), clipped);
        mismatches++;
        return;
      end
      want = readout_q.pop_front();
      if (raw !== want.raw_value) begin
        $error("raw_value: expected %0d, actual %0d", $signed(want.raw_value), $signed(raw));
        mismatches++;
      end
      if (clipped !== want.clipped_value) begin
        $error("clipped_value: expected %0d, actual %0d", want.clipped_value, clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_we        = 1'b0;
  logic [CLIP_W-1:0] cfg_wdata     = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // feature_a, feature_b, element, weight_value, zero pad
  logic [47:0]       s_axis_tdata  = '0;
  // command, side
  logic [3:0]        s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // raw_value, clipped_value, zero pad
  logic [23:0]       m_axis_tdata;

  accumulator_scoreboard sb;
  int                    full_rows [$];
  int unsigned           burst_left    = 0;
  int unsigned           results_seen  = 0;
  int unsigned           hold_left     = 0;
  int unsigned           pattern_age   = 0;
  int unsigned           cycle_count   = 0;
  logic [15:0]           stall_pattern = '1;
  logic [CLIP_W-1:0]     clip_plan [PHASES];

  sparse_feature_accumulator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      sb.check_result(m_axis_tdata[15:0], m_axis_tdata[22:16]);
      results_seen++;
      if (results_seen == LONG_HOLD_AT) begin
        hold_left = LONG_HOLD;
      end
    end
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '1;
        1: stall_pattern = 16'($urandom);
        2: stall_pattern = 16'($urandom | $urandom);
        default: stall_pattern = 16'($urandom & $urandom);
      endcase
      pattern_age = 64;
    end
    pattern_age--;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_pattern[pattern_age % 16];
    end
  end

  function automatic request_t make_request(logic [CMD_W-1:0] command, logic side,
                                            logic [FEAT_W-1:0] feature_a,
                                            logic [FEAT_W-1:0] feature_b,
                                            logic [ELEM_W-1:0] element,
                                            logic [WORD_W-1:0] weight_value);
    request_t rq;
    rq.command      = command;
    rq.side         = side;
    rq.feature_a    = feature_a;
    rq.feature_b    = feature_b;
    rq.element      = element;
    rq.weight_value = weight_value;
    return rq;
  endfunction

  function automatic logic [FEAT_W-1:0] pick_row();
    return FEAT_W'(full_rows[$urandom_range(0, full_rows.size() - 1)]);
  endfunction

  function automatic logic [WORD_W-1:0] random_weight();
    if ($urandom_range(0, 2) == 0) return WORD_W'($urandom_range(0, 600) - 300);
    return WORD_W'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    rq = make_request(CMD_READ, 1'($urandom), FEAT_W'($urandom), FEAT_W'($urandom),
                      ELEM_W'($urandom), random_weight());
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      rq.command = CMD_WRITE;
      if ($urandom_range(0, 3) != 0) rq.feature_a = pick_row();
    end else if (pick < 33) begin
      rq.command   = CMD_ADD;
      rq.feature_a = pick_row();
    end else if (pick < 48) begin
      rq.command   = CMD_REMOVE;
      rq.feature_a = pick_row();
    end else if (pick < 62) begin
      rq.command   = CMD_MOVE;
      rq.feature_a = pick_row();
      rq.feature_b = pick_row();
    end else if (pick < 66) begin
      rq.command = CMD_CLEAR;
    end else if (pick < 68) begin
      rq.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    end
    return rq;
  endfunction

  task automatic send_request(input request_t rq);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, rq.weight_value, rq.element, rq.feature_b, rq.feature_a};
    s_axis_tuser  <= {rq.side, rq.command};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_request(rq);
  endtask

  task automatic send(input logic [CMD_W-1:0] command, input logic side,
                      input logic [FEAT_W-1:0] feature_a, input logic [FEAT_W-1:0] feature_b,
                      input logic [ELEM_W-1:0] element, input logic [WORD_W-1:0] weight_value);
    send_request(make_request(command, side, feature_a, feature_b, element, weight_value));
  endtask

  task automatic load_row(input logic [FEAT_W-1:0] row, input int style);
    logic [WORD_W-1:0] value;
    for (int e = 0; e < ELEMENTS; e++) begin
      case (style)
        WEIGHTS_SMALL: value = WORD_W'($urandom_range(0, 600) - 300);
        WEIGHTS_POSITIVE: value = WORD_W'($urandom_range(0, 1023));
        default: begin
          value = WORD_W'($urandom);
          if (e == 0) value = 16'h7FFF;
          if (e == ELEMENTS - 1) value = 16'h8000;
        end
      endcase
      send(CMD_WRITE, 1'($urandom), row, FEAT_W'($urandom), ELEM_W'(e), value);
    end
    full_rows.push_back(int'(row));
  endtask

  task automatic write_clip(input logic [CLIP_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_clip(value);
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    clip_plan = '{CLIP_RESET, 15'd0, 15'd32767, 15'd64, 15'd8191, 15'd1000,
                  CLIP_W'($urandom), 15'd255};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_row(10'd1023, WEIGHTS_FULL);

    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b1, 10'd1023, 10'd1023, 8'd255, 16'hFFFF);
    send(CMD_ADD, 1'b0, 10'd1023, 10'd0, 8'd0, 16'h0000);
    send(CMD_ADD, 1'b1, 10'd1023, 10'd0, 8'd255, 16'hFFFF);
    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd255, 16'h0000);
    send(CMD_READ, 1'b1, 10'd0, 10'd0, 8'd255, 16'h0000);
    send(CMD_ADD, 1'b0, 10'd1023, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_REMOVE, 1'b1, 10'd1023, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b1, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_MOVE, 1'b0, 10'd1023, 10'd1023, 8'd0, 16'h0000);
    send(CMD_WRITE, 1'b0, 10'd1023, 10'd0, 8'd0, 16'h8000);
    send(CMD_WRITE, 1'b1, 10'd1023, 10'd1023, 8'd255, 16'h7FFF);
    send(CMD_ADD, 1'b1, 10'd1023, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b1, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b1, 10'd0, 10'd0, 8'd255, 16'h0000);
    send(CMD_SPARE_6, 1'b1, 10'd1023, 10'd1023, 8'd255, 16'hFFFF);
    send(CMD_SPARE_7, 1'b0, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_CLEAR, 1'b1, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd128, 16'h0000);
    send(CMD_READ, 1'b1, 10'd0, 10'd0, 8'd0, 16'h0000);
    send(CMD_REMOVE, 1'b0, 10'd1023, 10'd0, 8'd0, 16'h0000);
    send(CMD_READ, 1'b0, 10'd0, 10'd0, 8'd0, 16'h0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) write_clip(clip_plan[phase]);
      repeat (PHASE_REQUESTS) send_request(random_request());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
